[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the sorted table search block.
// No dependencies; each macro compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[hdl/stbs_pkg.sv]
// Shared types and constants for the sorted table binary search block.
// No dependencies; imported by the controller, datapath and top level.
package stbs_pkg;

	// Field widths fixed by the interface.
	localparam int DATA_W = 32;
	localparam int SLOT_W = 8;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 9;

	// Default table depth.
	localparam int TABLE_DEPTH_DEF = 256;

	// Operation codes carried in func.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;        // write value into the table at slot
		logic start;     // begin a search: set bounds, capture key, read first midpoint
		logic step;      // narrow bounds after a miss and read the next midpoint
		logic load_out;  // capture the result into the output register
	} stbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;    // bounds have not crossed
		logic match;     // probed entry equals the key
	} stbs_sts_t;

endpackage

[hdl/stbs_datapath.sv]
// Datapath of the sorted table search: table memory, bounds, key and result registers.
// Depends on stbs_pkg for field widths and the command and status structs.
module stbs_datapath import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stbs_cmd_t                cmd,
	output stbs_sts_t                sts,
	input  logic                     cfg_wr,
	input  logic [CNT_W-1:0]         cfg_data,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [DATA_W-1:0] value,
	output logic                     found,
	output logic [POS_W-1:0]         position
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = (CW > CNT_W) ? CW : CNT_W;

	logic [DATA_W-1:0]        mem [0:TABLE_DEPTH-1];
	logic signed [DATA_W-1:0] rd_data_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]         count_q;
	logic [CW-1:0]            lo_q, hi_q, lo_n, hi_n, n_clamp;
	logic [AW-1:0]            mid_q, mid_n;
	logic [CW:0]              sum;
	logic                     slot_ok;
	logic                     found_q;
	logic [POS_W-1:0]         position_q;

	// Entry count register, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr) begin
			count_q <= cfg_data;
		end
	end

	// Clamp the entry count to the table depth.
	assign n_clamp = (EW'(count_q) > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

	// Bounds are kept as a half-open range [lo, hi); the next midpoint follows them.
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (cmd.start) begin
			lo_n = '0;
			hi_n = n_clamp;
		end else if (cmd.step) begin
			if (rd_data_q < key_q) begin
				lo_n = CW'(mid_q) + CW'(1);
			end else begin
				hi_n = CW'(mid_q);
			end
		end
		sum   = {1'b0, lo_n} + {1'b0, hi_n} - (CW + 1)'(1);
		mid_n = AW'(sum >> 1);
	end

	// Search registers.
	always_ff @(posedge clk) begin
		if (cmd.start || cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (cmd.start) begin
			key_q <= value;
		end
	end

	// Table memory: one write port for loads, one registered read port for probes.
	assign slot_ok = (32'(slot) < 32'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.wr && slot_ok) begin
			mem[AW'(slot)] <= value;
		end
		if (cmd.start || cmd.step) begin
			rd_data_q <= mem[mid_n];
		end
	end

	assign sts.active = (lo_q < hi_q);
	assign sts.match  = (rd_data_q == key_q);

	// Output register; position is zero on a miss.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q    <= sts.active && sts.match;
			position_q <= (sts.active && sts.match) ? POS_W'(mid_q) : '0;
		end
	end

	assign found    = found_q;
	assign position = position_q;

endmodule

[hdl/stbs_controller.sv]
// Controller of the sorted table search: sequences loads, probes and result hand-off.
// Depends on stbs_pkg for the operation codes and the command and status structs.
module stbs_controller import stbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      func,
	output logic      out_valid,
	input  logic      out_ready,
	input  stbs_sts_t sts,
	output stbs_cmd_t cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	logic state_q, state_n;
	logic out_valid_q;
	logic accept;
	logic finish;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_PROBE) && (!sts.active || sts.match);

	// Command decode.
	always_comb begin
		cmd.wr       = accept && (func == FUNC_LOAD);
		cmd.start    = accept && (func == FUNC_SEARCH);
		cmd.step     = (state_q == ST_PROBE) && sts.active && !sts.match;
		cmd.load_out = finish && out_free;
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_n = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (cmd.load_out) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State and output valid; a result transaction clears valid unless a new one is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/sorted_table_binary_search.sv]
// Sorted table binary search: a load writes its table slot when accepted; a search over n
// entries probes the midpoint of the remaining range until it hits the key or the bounds cross.
// Probes run one per cycle through the table's registered read port.
// Searches are taken one at a time: the next one is accepted the cycle after the result is
// captured; loads are taken one per cycle while no search is in progress.
// Reset clears the entry count and the control state; table contents are undefined.
`include "assert_macros.svh"

module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CNT_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     found,
	output logic [POS_W-1:0]         position
);

	stbs_cmd_t cmd;
	stbs_sts_t sts;

	// The register port never stalls.
	assign cfg_ready = 1'b1;

	stbs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stbs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.slot     (slot),
		.value    (value),
		.found    (found),
		.position (position)
	);

	// Table writes and search starts happen only on an accepted input transaction.
	`ASSERT_SAME(a_cmd_on_accept, clk, arst_n, cmd.wr || cmd.start, in_valid && in_ready)
	// The bounds narrow only while they still overlap and the probe missed.
	`ASSERT_SAME(a_step_on_miss, clk, arst_n, cmd.step, sts.active && !sts.match)
	// A result is never captured in the same cycle as a probe step.
	`ASSERT_SAME(a_step_excl_out, clk, arst_n, cmd.step, !cmd.load_out && !cmd.start)
	// A captured result is offered on the next cycle.
	`ASSERT_NEXT(a_out_follows, clk, arst_n, cmd.load_out, out_valid)

endmodule
